FILE: hw/rtl/apor_pkg.sv
// apor_pkg: shared constants and types for the box push-out resolver.
// No dependencies; used by apor_axis and aabb_push_out_resolver.
package apor_pkg;

    // Default coordinate width (signed Q19.4)
    localparam int COORD_WIDTH_DEF = 24;

    // Footprint size registers, unsigned Q12.4
    localparam int SIZE_W = 16;
    localparam logic [SIZE_W-1:0] FEET_WIDTH_RST  = 16'd256;
    localparam logic [SIZE_W-1:0] FEET_HEIGHT_RST = 16'd179;

    // Config register index
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEET_WIDTH  = 4'd0,
        REG_FEET_HEIGHT = 4'd1
    } cfg_reg_t;

    // Width for internal sums: coordinate plus size never wraps
    function automatic int ext_width(input int cw);
        ext_width = ((cw > SIZE_W) ? cw : SIZE_W + 1) + 2;
    endfunction

endpackage

FILE: hw/rtl/apor_axis.sv
// apor_axis: one-axis overlap margin and push-out target.
// Depends on apor_pkg (COORD_WIDTH_DEF, ext_width, SIZE_W).
module apor_axis #(
    parameter int CW = apor_pkg::COORD_WIDTH_DEF,
    parameter int XW = apor_pkg::ext_width(apor_pkg::COORD_WIDTH_DEF)
) (
    input  logic signed [CW-1:0]               cur,
    input  logic signed [CW-1:0]               oth,
    input  logic        [apor_pkg::SIZE_W-1:0] size,
    output logic signed [XW-1:0]               margin,   // size - |cur - oth|
    output logic                               hit,      // strict overlap on this axis
    output logic signed [CW-1:0]               target    // pushed-out coordinate, saturated
);

    localparam logic signed [XW-1:0] C_MAX = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] C_MIN = XW'(-(64'sd1 <<< (CW - 1)));

    logic signed [XW-1:0] cur_x;
    logic signed [XW-1:0] oth_x;
    logic signed [XW-1:0] size_x;
    logic signed [XW-1:0] diff;
    logic signed [XW-1:0] adiff;
    logic signed [XW-1:0] tgt;

    always_comb
    begin
        cur_x  = XW'(cur);
        oth_x  = XW'(oth);
        size_x = signed'(XW'(size));
        diff   = cur_x - oth_x;
        adiff  = diff[XW-1] ? -diff : diff;
        margin = size_x - adiff;
        hit    = !margin[XW-1] && (margin != '0);
        // mover left of other: lands at oth - size, else at oth + size
        tgt    = diff[XW-1] ? (oth_x - size_x) : (oth_x + size_x);
        if (tgt > C_MAX)
            target = CW'(C_MAX);
        else if (tgt < C_MIN)
            target = CW'(C_MIN);
        else
            target = CW'(tgt);
    end

endmodule

FILE: hw/rtl/aabb_push_out_resolver.sv
// aabb_push_out_resolver: top level, resolves a mover box against a box stream.
// Depends on apor_pkg and apor_axis.
//
// Usage:
//  - in channel (in_valid/in_ready): one beat per other box. A beat with
//    first set loads the mover from start_x/start_y before testing.
//    other_counts clear means the box is skipped (no push).
//  - out channel (out_valid/out_ready): one beat per input beat, in order,
//    carrying the mover position after that box, pushed, and last_out.
//  - cfg channel (cfg_valid/cfg_ready): writes feet_width (index 0) or
//    feet_height (index 1); always ready. Write only while the block is idle.
// Timing:
//  - Input register, then one combinational pass
//    (subtract, abs, compare, add, saturate) into the result register.
//  - One box per cycle when not stalled; the running position register
//    closes its loop in that single pass, so back-to-back boxes chain directly.
// Stall: if the receiver holds out_ready low, the result register holds,
//  the input register fills, then in_ready drops. No beat is lost.
// Reset: position returns to (0,0), sizes to 256 and 179 (Q12.4), both
//  stages empty. Boxes before a first beat start the mover from (0,0).
module aabb_push_out_resolver #(
    parameter int COORD_WIDTH = apor_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [apor_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [apor_pkg::SIZE_W-1:0]    cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  first,
    input  logic signed [COORD_WIDTH-1:0]         start_x,
    input  logic signed [COORD_WIDTH-1:0]         start_y,
    input  logic signed [COORD_WIDTH-1:0]         other_x,
    input  logic signed [COORD_WIDTH-1:0]         other_y,
    input  logic                                  other_counts,
    input  logic                                  last_in,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_WIDTH-1:0]         pos_x,
    output logic signed [COORD_WIDTH-1:0]         pos_y,
    output logic                                  pushed,
    output logic                                  last_out
);

    localparam int CW = COORD_WIDTH;
    localparam int XW = apor_pkg::ext_width(COORD_WIDTH);

    // config registers
    logic [apor_pkg::SIZE_W-1:0] feet_w_reg;
    logic [apor_pkg::SIZE_W-1:0] feet_h_reg;

    // input stage
    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic signed [CW-1:0] s1_start_x_reg;
    logic signed [CW-1:0] s1_start_y_reg;
    logic signed [CW-1:0] s1_other_x_reg;
    logic signed [CW-1:0] s1_other_y_reg;
    logic                 s1_counts_reg;
    logic                 s1_last_reg;

    // running mover position
    logic signed [CW-1:0] cur_x_reg;
    logic signed [CW-1:0] cur_y_reg;

    // result stage
    logic                 out_valid_reg;
    logic signed [CW-1:0] pos_x_reg;
    logic signed [CW-1:0] pos_y_reg;
    logic                 pushed_reg;
    logic                 last_reg;

    logic                 in_acc;
    logic                 s1_adv;
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] my;
    logic signed [XW-1:0] margin_x;
    logic signed [XW-1:0] margin_y;
    logic                 hit_x;
    logic                 hit_y;
    logic signed [CW-1:0] tgt_x;
    logic signed [CW-1:0] tgt_y;
    logic                 overlap;
    logic                 push_on_x;
    logic signed [CW-1:0] cur_x_next;
    logic signed [CW-1:0] cur_y_next;

    assign cfg_ready = 1'b1;

    // result register frees up when empty or being drained
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    // first beat of a pass takes the start position
    assign mx = s1_first_reg ? s1_start_x_reg : cur_x_reg;
    assign my = s1_first_reg ? s1_start_y_reg : cur_y_reg;

    apor_axis #(.CW(CW), .XW(XW)) u_axis_x (
        .cur    (mx),
        .oth    (s1_other_x_reg),
        .size   (feet_w_reg),
        .margin (margin_x),
        .hit    (hit_x),
        .target (tgt_x)
    );

    apor_axis #(.CW(CW), .XW(XW)) u_axis_y (
        .cur    (my),
        .oth    (s1_other_y_reg),
        .size   (feet_h_reg),
        .margin (margin_y),
        .hit    (hit_y),
        .target (tgt_y)
    );

    // margin is the magnitude of the minimal translation; tie pushes on y
    always_comb
    begin
        overlap    = s1_counts_reg && hit_x && hit_y;
        push_on_x  = overlap && (margin_x < margin_y);
        cur_x_next = push_on_x ? tgt_x : mx;
        cur_y_next = (overlap && !push_on_x) ? tgt_y : my;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feet_w_reg <= apor_pkg::FEET_WIDTH_RST;
            feet_h_reg <= apor_pkg::FEET_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                apor_pkg::REG_FEET_WIDTH:  feet_w_reg <= cfg_data;
                apor_pkg::REG_FEET_HEIGHT: feet_h_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
        end
        else
        begin
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_first_reg   <= first;
            s1_start_x_reg <= start_x;
            s1_start_y_reg <= start_y;
            s1_other_x_reg <= other_x;
            s1_other_y_reg <= other_y;
            s1_counts_reg  <= other_counts;
            s1_last_reg    <= last_in;
        end
        if (s1_adv)
        begin
            pos_x_reg  <= cur_x_next;
            pos_y_reg  <= cur_y_next;
            pushed_reg <= overlap;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pushed    = pushed_reg;
    assign last_out  = last_reg;

    // result beat always matches the running position it came from
    a_pos_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (pos_x == cur_x_reg) && (pos_y == cur_y_reg))
        else $error("result position differs from running position");

    // input stalls only with both stages full and the receiver stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a full pipeline");

    // a skipped box never reports a push
    a_skip_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_counts_reg) |=> !pushed)
        else $error("push reported for a box that does not count");

    // one axis moves per push; here: none moves without a push or first beat
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_first_reg && !overlap) |=>
            (pos_x == $past(cur_x_reg)) && (pos_y == $past(cur_y_reg)))
        else $error("position moved without a push");

endmodule

FILE: dv/tb_aabb_push_out_resolver.sv
// tb_aabb_push_out_resolver: self-checking bench for the box push-out resolver.
// Depends on apor_pkg and the aabb_push_out_resolver RTL; a built-in predictor
// tracks the mover position and checks every output beat in order.
`timescale 1ns / 1ps

module tb_aabb_push_out_resolver;

    localparam int CW = apor_pkg::COORD_WIDTH_DEF;
    localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 9;
    localparam int SETTLE_CYCLES = 4;

    // One input beat: mover start (used when first is set) plus one other box.
    typedef struct {
        logic                 first;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] other_x;
        logic signed [CW-1:0] other_y;
        logic                 other_counts;
        logic                 last_in;
    } box_item_t;

    // One output beat: mover position after the box.
    typedef struct {
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic                 pushed;
        logic                 last_flag;
    } box_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [apor_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [apor_pkg::SIZE_W-1:0]    cfg_data = '0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    box_item_t drv_box = '{default: '0};

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic                 pushed;
    logic                 last_out;

    // Predictor state: footprint size shadow and the running mover position.
    logic [apor_pkg::SIZE_W-1:0] size_w = apor_pkg::FEET_WIDTH_RST;
    logic [apor_pkg::SIZE_W-1:0] size_h = apor_pkg::FEET_HEIGHT_RST;
    logic signed [CW-1:0]        mover_x = '0;
    logic signed [CW-1:0]        mover_y = '0;

    box_item_t   box_queue[$];    // boxes waiting to be driven
    box_result_t mover_track[$];  // predicted positions not yet seen on the output

    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_errors = 0;
    int   cycle_count = 0;
    logic in_took = 1'b0;   // input beat accepted at the last rising edge
    logic calm = 1'b0;      // suppresses all idling on both sides

    aabb_push_out_resolver #(
        .COORD_WIDTH (CW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first        (drv_box.first),
        .start_x      (drv_box.start_x),
        .start_y      (drv_box.start_y),
        .other_x      (drv_box.other_x),
        .other_y      (drv_box.other_y),
        .other_counts (drv_box.other_counts),
        .last_in      (drv_box.last_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pushed       (pushed),
        .last_out     (last_out)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------
    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX)
        begin
            return CW'(COORD_MAX);
        end
        if (v < COORD_MIN)
        begin
            return CW'(COORD_MIN);
        end
        return CW'(v);
    endfunction

    // Resolve one box against the mover and advance the mover state.
    // Sizes share the Q.4 binary point with positions, so all of this is
    // plain integer math in 64 bits, far wider than any sum can get.
    function automatic box_result_t resolve_box(input box_item_t b);
        box_result_t r;
        longint w, h, mx, my, ox, oy;
        longint gap_l, gap_r, gap_t, gap_b, dx, dy;
        w = longint'(size_w);
        h = longint'(size_h);
        if (b.first)
        begin
            mover_x = b.start_x;
            mover_y = b.start_y;
        end
        mx = longint'(mover_x);
        my = longint'(mover_y);
        r.pushed = 1'b0;
        if (b.other_counts)
        begin
            ox = longint'(b.other_x);
            oy = longint'(b.other_y);
            gap_l = mx + w - ox;
            gap_r = ox + w - mx;
            gap_t = my + h - oy;
            gap_b = oy + h - my;
            // strict overlap only: touching edges leave a zero gap
            if (gap_l > 0 && gap_r > 0 && gap_t > 0 && gap_b > 0)
            begin
                dx = (gap_l < gap_r) ? gap_l : -gap_r;
                dy = (gap_t < gap_b) ? gap_t : -gap_b;
                // equal magnitudes push along y
                if (magnitude(dx) < magnitude(dy))
                begin
                    mover_x = clamp_coord(mx - dx);
                end
                else
                begin
                    mover_y = clamp_coord(my - dy);
                end
                r.pushed = 1'b1;
            end
        end
        r.pos_x = mover_x;
        r.pos_y = mover_y;
        r.last_flag = b.last_in;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: updates inputs on the falling edge, one assignment per signal
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            // slot is free: present the next box unless the sender idles
            if (box_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                drv_box <= box_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: samples handshakes on the rising edge, predicts and checks
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        box_result_t want;
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && in_ready;

            if (cfg_valid && cfg_ready)
            begin
                case (apor_pkg::cfg_reg_t'(cfg_index))
                    apor_pkg::REG_FEET_WIDTH:  size_w <= cfg_data;
                    apor_pkg::REG_FEET_HEIGHT: size_h <= cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                mover_track.push_back(resolve_box(drv_box));
                n_accepted++;
            end

            if (out_valid && out_ready)
            begin
                if (mover_track.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("unexpected output beat: x=%0d y=%0d pushed=%0b last=%0b",
                                 pos_x, pos_y, pushed, last_out);
                    end
                end
                else
                begin
                    want = mover_track.pop_front();
                    if (pos_x !== want.pos_x || pos_y !== want.pos_y ||
                        pushed !== want.pushed || last_out !== want.last_flag)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                        begin
                            $display("mismatch: want x=%0d y=%0d pushed=%0b last=%0b",
                                     want.pos_x, want.pos_y, want.pushed, want.last_flag);
                            $display("          got  x=%0d y=%0d pushed=%0b last=%0b",
                                     pos_x, pos_y, pushed, last_out);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_box(input logic f, input longint sx, input longint sy,
                             input longint ox, input longint oy,
                             input logic counts, input logic lst);
        box_item_t b;
        b.first = f;
        b.start_x = CW'(sx);
        b.start_y = CW'(sy);
        b.other_x = CW'(ox);
        b.other_y = CW'(oy);
        b.other_counts = counts;
        b.last_in = lst;
        box_queue.push_back(b);
        n_queued++;
    endtask

    // Mostly small coordinates, some full-range, some hugging the extremes
    function automatic longint rand_coord();
        case ($urandom_range(9))
            6, 7:    return longint'($signed(CW'($urandom)));
            8:       return COORD_MAX - $urandom_range(300);
            9:       return COORD_MIN + $urandom_range(300);
            default: return longint'($urandom_range(8191)) - 4096;
        endcase
    endfunction

    function automatic longint near(input longint base, input int spread);
        return base + longint'($urandom_range(2 * spread)) - spread;
    endfunction

    function automatic logic [apor_pkg::SIZE_W-1:0] rand_size();
        case ($urandom_range(4))
            0:       return apor_pkg::SIZE_W'($urandom_range(15));
            1:       return apor_pkg::SIZE_W'($urandom_range(1024, 64));
            2:       return apor_pkg::SIZE_W'($urandom_range(65535));
            3:       return 16'hFFFF;
            default: return apor_pkg::FEET_WIDTH_RST;
        endcase
    endfunction

    // Mostly well-formed passes clustered around the start so boxes overlap;
    // the rest are loose beats with random flags and coordinates.
    task automatic queue_traffic(input int count);
        int     done_n, len, spread;
        longint sx, sy;
        done_n = 0;
        spread = 2 * ((size_w > size_h) ? int'(size_w) : int'(size_h)) + 16;
        while (done_n < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                len = $urandom_range(12, 1);
                sx = rand_coord();
                sy = rand_coord();
                for (int k = 0; k < len; k++)
                begin
                    queue_box(k == 0, (k == 0) ? sx : rand_coord(),
                              (k == 0) ? sy : rand_coord(),
                              near(sx, spread), near(sy, spread),
                              $urandom_range(99) < 85, k == len - 1);
                end
                done_n += len;
            end
            else
            begin
                queue_box(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                done_n++;
            end
        end
    endtask

    // Register write; returns on a rising edge so queueing never races the driver
    task automatic write_reg(input apor_pkg::cfg_reg_t idx,
                             input logic [apor_pkg::SIZE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Block is idle once every box went in and every position came out
    task automatic wait_idle();
        while (n_accepted != n_queued || mover_track.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [apor_pkg::SIZE_W-1:0] phase_w[6] =
        '{16'd0, 16'd256, 16'hFFFF, 16'd256, 16'd1, 16'hFFFF};
    logic [apor_pkg::SIZE_W-1:0] phase_h[6] =
        '{16'd179, 16'd0, 16'hFFFF, 16'd179, 16'd1, 16'd0};

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset sizes (256 x 179).
        // mover still at the reset origin, no first beat yet
        queue_box(1'b0, 0, 0, 100, 50, 1'b1, 1'b0);
        // overlapping box that does not count
        queue_box(1'b0, 0, 0, 0, 0, 1'b0, 1'b0);
        // edges touching in x, then in y: no push
        queue_box(1'b1, 0, 0, 256, 0, 1'b1, 1'b0);
        queue_box(1'b1, 0, 0, 0, 179, 1'b1, 1'b0);
        // equal translations on both axes: y wins
        queue_box(1'b1, 0, 0, 100, 23, 1'b1, 1'b0);
        // short x push in both directions
        queue_box(1'b1, 0, 0, 200, 0, 1'b1, 1'b0);
        queue_box(1'b1, 0, 0, -200, 10, 1'b1, 1'b0);
        // y pushed past the top and bottom of the range: saturates
        queue_box(1'b1, 0, COORD_MAX, 0, COORD_MAX - 10, 1'b1, 1'b0);
        queue_box(1'b1, 0, COORD_MIN, 0, COORD_MIN + 10, 1'b1, 1'b0);
        // opposite corners, widest sums, then both boxes on one corner
        queue_box(1'b1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        queue_box(1'b1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
        queue_box(1'b1, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
        // all-ones coordinates, same spot; then a box that does not count
        queue_box(1'b1, -1, -1, -1, -1, 1'b1, 1'b0);
        queue_box(1'b1, 5, 5, 0, 0, 1'b0, 1'b1);
        // a short well-formed pass where pushes chain
        queue_box(1'b1, 1000, 1000, 1100, 1050, 1'b1, 1'b0);
        queue_box(1'b0, 0, 0, 900, 990, 1'b1, 1'b0);
        queue_box(1'b0, 0, 0, 1000, 1000, 1'b1, 1'b0);
        queue_box(1'b0, 0, 0, 1200, 800, 1'b1, 1'b1);
        wait_idle();

        // Narrow, tall footprint so x wins and saturates at both ends
        write_reg(apor_pkg::REG_FEET_WIDTH, 16'd16);
        write_reg(apor_pkg::REG_FEET_HEIGHT, 16'd1000);
        queue_box(1'b1, COORD_MAX, 0, COORD_MAX - 4, 0, 1'b1, 1'b0);
        queue_box(1'b1, COORD_MIN, 0, COORD_MIN + 4, 0, 1'b1, 1'b1);
        queue_traffic(100);
        wait_idle();

        // Fixed corner settings first, then random sizes; one long calm phase
        for (int p = 0; p < 12; p++)
        begin
            if (p < 6)
            begin
                write_reg(apor_pkg::REG_FEET_WIDTH, phase_w[p]);
                write_reg(apor_pkg::REG_FEET_HEIGHT, phase_h[p]);
            end
            else
            begin
                write_reg(apor_pkg::REG_FEET_WIDTH, rand_size());
                write_reg(apor_pkg::REG_FEET_HEIGHT, rand_size());
            end
            calm = (p == 3);
            queue_traffic((p == 3) ? 300 : 120);
            wait_idle();
        end
        calm = 1'b0;

        // drain window: any stray beat now shows up as unexpected
        repeat (8) @(posedge clk);
        if (n_errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
